// File: src/elf_section_layout_and_relocation_core_macros.svh
// Assertion macros shared by the section layout and relocation core.
// Included by every RTL file that carries concurrent assertions; no dependencies.
`ifndef ELF_SECTION_LAYOUT_AND_RELOCATION_CORE_MACROS_SVH
`define ELF_SECTION_LAYOUT_AND_RELOCATION_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ESLR_ASSERT_ALWAYS(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);

// Same-cycle implication.
`define ESLR_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ESLR_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/eslr_pkg.sv
// Shared types, codes and helper functions of the section layout and relocation core.
// No dependencies; imported by every module of the block except eslr_ram.
package eslr_pkg;

	localparam int MAX_SECTIONS_DEF = 64;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam logic [31:0] NOT_PLACED = 32'hFFFF_FFFF;

	localparam logic [15:0] SHN_UNDEF   = 16'h0000;
	localparam logic [15:0] SHN_RES_LO  = 16'hFF00;
	localparam logic [15:0] SHN_ABS     = 16'hFFF1;
	localparam logic [15:0] SHN_COMMON  = 16'hFFF2;

	localparam logic [31:0] R_NONE  = 32'd0;
	localparam logic [31:0] R_64    = 32'd1;
	localparam logic [31:0] R_PC32  = 32'd2;
	localparam logic [31:0] R_PLT32 = 32'd4;
	localparam logic [31:0] R_32    = 32'd10;
	localparam logic [31:0] R_32S   = 32'd11;

	localparam logic [1:0] KIND_NOBITS = 2'd1;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_DEST_BASE   = 2'd0;
	localparam logic [1:0] REG_DEST_LEN    = 2'd1;
	localparam logic [1:0] REG_IMAGE_LIMIT = 2'd2;

	localparam logic [31:0] IMAGE_LIMIT_RST = 32'd16777216;

	typedef enum logic [1:0] {
		CMD_SECTION = 2'd0,
		CMD_END     = 2'd1,
		CMD_RELOC   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_FORMAT = 3'd1,
		ST_TOOBIG = 3'd2,
		ST_RELOC  = 3'd3,
		ST_RANGE  = 3'd4,
		ST_UNDEF  = 3'd5
	} status_t;

	// PLT32 is computed exactly like PC32
	typedef enum logic [2:0] {
		RT_NONE,
		RT_64,
		RT_PC32,
		RT_32,
		RT_32S,
		RT_UNK
	} rtype_t;

	typedef enum logic [2:0] {
		SYM_UNDEF,
		SYM_ABS,
		SYM_COMMON,
		SYM_BAD,
		SYM_SEC
	} sym_t;

	typedef struct packed {
		logic [63:0] dest_base;
		logic [31:0] dest_len;
		logic [31:0] image_limit;
	} cfg_t;

	// One entry of the front-to-back queue. done marks a finished result.
	typedef struct packed {
		logic        done;
		status_t     st;
		logic [31:0] placed;
		rtype_t      rt;
		logic [63:0] roff;
		logic [63:0] bo_t;
		logic [63:0] s_a;
		logic [63:0] s_b;
		logic [63:0] addend;
	} rec_t;

	function automatic rtype_t classify_type(input logic [31:0] t);
		rtype_t r;
		case (t)
			R_NONE:          r = RT_NONE;
			R_64:            r = RT_64;
			R_PC32, R_PLT32: r = RT_PC32;
			R_32:            r = RT_32;
			R_32S:           r = RT_32S;
			default:         r = RT_UNK;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] site_width(input rtype_t r);
		logic [3:0] w;
		case (r)
			RT_NONE:                 w = 4'd0;
			RT_PC32, RT_32, RT_32S:  w = 4'd4;
			default:                 w = 4'd8;
		endcase
		return w;
	endfunction

	// True when a 64-bit value read as signed fits in 32 signed bits
	function automatic logic fits_s32(input logic [63:0] v);
		return (&v[63:31]) || (~|v[63:31]);
	endfunction

endpackage

// File: src/eslr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eslr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/eslr_front.sv
// Front part: accepts items, lays out sections, answers end items and
// classifies relocations against the section tables. Uses eslr_pkg and eslr_ram.
`include "elf_section_layout_and_relocation_core_macros.svh"
module eslr_front #(
	parameter int MAX_SECTIONS = eslr_pkg::MAX_SECTIONS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  eslr_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    cmd,
	input  logic          sec_alloc,
	input  logic [1:0]    sec_kind,
	input  logic [63:0]   sec_align,
	input  logic [63:0]   sec_size,
	input  logic [31:0]   rel_type,
	input  logic [63:0]   rel_offset,
	input  logic [5:0]    rel_target,
	input  logic [15:0]   sym_shndx,
	input  logic [63:0]   sym_value,
	input  logic [63:0]   resolved_addr,
	input  logic [63:0]   addend,
	output logic          push,
	output eslr_pkg::rec_t push_rec,
	input  logic          q_full
);
	import eslr_pkg::*;

	localparam int IDXW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNTW = $clog2(MAX_SECTIONS + 1);
	localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_SECTIONS);

	logic            accept;
	logic [32:0]     cursor_q;
	logic [CNTW-1:0] cnt_q;

	// section layout
	logic [63:0] align_a;
	logic [12:0] am1;
	logic        align_ok;
	logic [32:0] bumped;
	logic [32:0] cur;
	logic [31:0] room;
	logic        too_big;
	logic        full;
	logic        placeable;
	status_t     sec_st;
	logic [31:0] sec_off;
	logic        sec_place;
	status_t     end_st;
	logic [31:0] end_off;

	// relocation classify
	logic            tgt_oor;
	sym_t            sym_cls;
	logic [IDXW+5:0]  tgt_x;
	logic [IDXW+15:0] shx_x;
	logic [63:0]     rd_t;
	logic [31:0]     rd_s;

	// stage 1
	logic        v_s1;
	logic        done_s1;
	status_t     st_s1;
	logic [31:0] placed_s1;
	logic        tgt_oor_s1;
	sym_t        sym_s1;
	rtype_t      rt_s1;
	logic [63:0] roff_s1;
	logic [63:0] sval_s1;
	logic [63:0] res_s1;
	logic [63:0] addend_s1;

	logic [31:0] off_t;
	logic [31:0] len_t;
	logic [31:0] off_s;
	logic [32:0] rem;
	logic [3:0]  width;
	logic        bnd_fail;

	assign in_stall = v_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = v_s1 && !q_full;

	// Align the cursor, check the image limit and form the section and end item status
	always_comb begin
		align_a   = (sec_align == 64'd0) ? 64'd1 : sec_align;
		am1       = align_a[12:0] - 13'd1;
		align_ok  = (align_a[63:13] == 51'd0) && ((align_a[12:0] & am1) == 13'd0);
		bumped    = cursor_q + {20'd0, am1};
		cur       = bumped & ~{20'd0, am1};
		room      = cfg.image_limit - cur[31:0];
		too_big   = (cur > {1'b0, cfg.image_limit}) || (sec_size[63:32] != 32'd0) ||
			(sec_size[31:0] > room);
		full      = (cnt_q == CNT_MAX);
		placeable = sec_alloc && (sec_kind <= KIND_NOBITS);

		sec_st    = ST_OK;
		sec_off   = NOT_PLACED;
		sec_place = 1'b0;
		if (full) begin
			sec_st = ST_FORMAT;
		end else if (placeable) begin
			if (!align_ok) begin
				sec_st = ST_FORMAT;
			end else if (too_big) begin
				sec_st = ST_TOOBIG;
			end else begin
				sec_place = 1'b1;
				sec_off   = cur[31:0];
			end
		end

		end_st  = ST_OK;
		end_off = cursor_q[31:0];
		if (cursor_q == 33'd0) begin
			end_st  = ST_FORMAT;
			end_off = 32'd0;
		end else if (cursor_q > {1'b0, cfg.dest_len}) begin
			end_st  = ST_TOOBIG;
			end_off = 32'd0;
		end
	end

	always_comb begin
		tgt_oor = ({26'd0, rel_target} >= 32'(cnt_q));
		tgt_x   = {{IDXW{1'b0}}, rel_target};
		shx_x   = {{IDXW{1'b0}}, sym_shndx};
		if (sym_shndx == SHN_UNDEF) begin
			sym_cls = SYM_UNDEF;
		end else if (sym_shndx == SHN_ABS) begin
			sym_cls = SYM_ABS;
		end else if (sym_shndx == SHN_COMMON) begin
			sym_cls = SYM_COMMON;
		end else if (sym_shndx >= SHN_RES_LO || {16'd0, sym_shndx} >= 32'(cnt_q)) begin
			sym_cls = SYM_BAD;
		end else begin
			sym_cls = SYM_SEC;
		end
	end

	// Target table holds {offset, length}, symbol table holds offset only
	eslr_ram #(.WIDTH(64), .DEPTH(MAX_SECTIONS)) u_tgt_ram (
		.clk   (clk),
		.we    (accept && cmd == CMD_SECTION && !full),
		.waddr (cnt_q[IDXW-1:0]),
		.wdata ({sec_off, sec_place ? sec_size[31:0] : 32'd0}),
		.re    (accept && cmd == CMD_RELOC),
		.raddr (tgt_x[IDXW-1:0]),
		.rdata (rd_t)
	);

	eslr_ram #(.WIDTH(32), .DEPTH(MAX_SECTIONS)) u_sym_ram (
		.clk   (clk),
		.we    (accept && cmd == CMD_SECTION && !full),
		.waddr (cnt_q[IDXW-1:0]),
		.wdata (sec_off),
		.re    (accept && cmd == CMD_RELOC),
		.raddr (shx_x[IDXW-1:0]),
		.rdata (rd_s)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= 33'd0;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
		end else begin
			if (accept && cmd == CMD_SECTION && !full) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (sec_place) begin
					cursor_q <= cur + {1'b0, sec_size[31:0]};
				end
			end
			if (accept && (cmd == CMD_SECTION || cmd == CMD_END || cmd == CMD_RELOC)) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			done_s1    <= (cmd != CMD_RELOC);
			st_s1      <= (cmd == CMD_SECTION) ? sec_st : end_st;
			placed_s1  <= (cmd == CMD_SECTION) ? sec_off : end_off;
			tgt_oor_s1 <= tgt_oor;
			sym_s1     <= sym_cls;
			rt_s1      <= classify_type(rel_type);
			roff_s1    <= rel_offset;
			sval_s1    <= sym_value;
			res_s1     <= resolved_addr;
			addend_s1  <= addend;
		end
	end

	// Check the patch site and the symbol, then form the queue entry
	always_comb begin
		off_t    = rd_t[63:32];
		len_t    = rd_t[31:0];
		off_s    = rd_s;
		width    = site_width(rt_s1);
		rem      = {1'b0, len_t} - {1'b0, roff_s1[31:0]};
		bnd_fail = (roff_s1[63:32] != 32'd0) || rem[32] || (rem[31:0] < {28'd0, width});

		push_rec        = '0;
		push_rec.rt     = rt_s1;
		push_rec.roff   = roff_s1;
		push_rec.bo_t   = cfg.dest_base + {32'd0, off_t};
		push_rec.s_a    = (sym_s1 == SYM_SEC) ? (cfg.dest_base + {32'd0, off_s}) : 64'd0;
		push_rec.s_b    = (sym_s1 == SYM_UNDEF) ? res_s1 : sval_s1;
		push_rec.addend = addend_s1;
		push_rec.done   = 1'b1;
		push_rec.st     = ST_OK;
		push_rec.placed = 32'd0;
		if (done_s1) begin
			push_rec.st     = st_s1;
			push_rec.placed = placed_s1;
		end else if (tgt_oor_s1) begin
			push_rec.st = ST_FORMAT;
		end else if (off_t == NOT_PLACED) begin
			push_rec.st = ST_OK;
		end else if (bnd_fail) begin
			push_rec.st = ST_FORMAT;
		end else if ((sym_s1 == SYM_UNDEF && res_s1 == 64'd0) || sym_s1 == SYM_COMMON) begin
			push_rec.st = ST_UNDEF;
		end else if (sym_s1 == SYM_BAD || (sym_s1 == SYM_SEC && off_s == NOT_PLACED)) begin
			push_rec.st = ST_FORMAT;
		end else if (rt_s1 == RT_UNK) begin
			push_rec.st = ST_RELOC;
		end else begin
			push_rec.done = 1'b0;
		end
	end

	`ESLR_ASSERT_ALWAYS(a_cursor_32b, clk, arst_n, !cursor_q[32], "layout cursor overflowed 32 bits")
	`ESLR_ASSERT_ALWAYS(a_cnt_max, clk, arst_n, cnt_q <= CNT_MAX, "section count past table size")
	`ESLR_ASSERT_NEXT(a_s1_hold, clk, arst_n, v_s1 && q_full, v_s1 && $stable(placed_s1),
		"front stage lost a held item")

endmodule

// File: src/eslr_queue.sv
// Short queue of classified items between the front and back parts.
// Uses eslr_pkg for the entry type.
`include "elf_section_layout_and_relocation_core_macros.svh"
module eslr_queue #(
	parameter int DEPTH = eslr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  eslr_pkg::rec_t din,
	output logic           full,
	input  logic           pop,
	output eslr_pkg::rec_t dout,
	output logic           empty
);
	import eslr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`ESLR_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !full, "push into full queue")
	`ESLR_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, !empty, "pop from empty queue")
	`ESLR_ASSERT_NEXT(a_cnt_inc, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + CW'(1),
		"queue count did not advance on push")

endmodule

// File: src/eslr_back.sv
// Back part: resolves symbol and site addresses, computes relocation values
// and range checks, and holds the result beat. Uses eslr_pkg.
`include "elf_section_layout_and_relocation_core_macros.svh"
module eslr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  eslr_pkg::rec_t q_dout,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     status,
	output logic [31:0]    placed_offset,
	output logic [63:0]    patch_addr,
	output logic [63:0]    patch_data,
	output logic [3:0]     patch_bytes
);
	import eslr_pkg::*;

	logic rdy1;
	logic rdy2;
	logic rdy3;

	// stage 1: site address P and symbol value S
	logic        v_s1;
	logic        done_s1;
	status_t     st_s1;
	logic [31:0] placed_s1;
	rtype_t      rt_s1;
	logic [63:0] p_s1;
	logic [63:0] s_s1;
	logic [63:0] add_s1;

	// stage 2: S + A and its range flags
	logic        v_s2;
	logic        done_s2;
	status_t     st_s2;
	logic [31:0] placed_s2;
	rtype_t      rt_s2;
	logic [63:0] p_s2;
	logic [63:0] val_s2;
	logic        u32_ok_s2;
	logic        s32_ok_s2;

	logic [63:0] sum;

	// stage 3: result beat
	logic        v_s3;
	status_t     st_s3;
	logic [31:0] placed_s3;
	logic [63:0] addr_s3;
	logic [63:0] data_s3;
	logic [3:0]  bytes_s3;

	logic [63:0] pcrel;
	status_t     r_st;
	logic [63:0] r_addr;
	logic [63:0] r_data;
	logic [3:0]  r_bytes;

	assign rdy3 = !v_s3 || !out_stall;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pop  = !q_empty && rdy1;

	assign sum = s_s1 + add_s1;

	always_comb begin
		pcrel   = val_s2 - p_s2;
		r_st    = ST_OK;
		r_addr  = 64'd0;
		r_data  = 64'd0;
		r_bytes = 4'd0;
		if (done_s2) begin
			r_st = st_s2;
		end else begin
			case (rt_s2)
				RT_NONE: begin
					r_addr = p_s2;
				end
				RT_64: begin
					r_addr  = p_s2;
					r_data  = val_s2;
					r_bytes = 4'd8;
				end
				RT_PC32: begin
					if (fits_s32(pcrel)) begin
						r_addr  = p_s2;
						r_data  = {32'd0, pcrel[31:0]};
						r_bytes = 4'd4;
					end else begin
						r_st = ST_RANGE;
					end
				end
				RT_32: begin
					if (u32_ok_s2) begin
						r_addr  = p_s2;
						r_data  = val_s2;
						r_bytes = 4'd4;
					end else begin
						r_st = ST_RANGE;
					end
				end
				RT_32S: begin
					if (s32_ok_s2) begin
						r_addr  = p_s2;
						r_data  = {32'd0, val_s2[31:0]};
						r_bytes = 4'd4;
					end else begin
						r_st = ST_RANGE;
					end
				end
				default: begin
					r_st = ST_RELOC;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= pop;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			done_s1   <= q_dout.done;
			st_s1     <= q_dout.st;
			placed_s1 <= q_dout.placed;
			rt_s1     <= q_dout.rt;
			p_s1      <= q_dout.bo_t + q_dout.roff;
			s_s1      <= q_dout.s_a + q_dout.s_b;
			add_s1    <= q_dout.addend;
		end
		if (rdy2 && v_s1) begin
			done_s2   <= done_s1;
			st_s2     <= st_s1;
			placed_s2 <= placed_s1;
			rt_s2     <= rt_s1;
			p_s2      <= p_s1;
			val_s2    <= sum;
			u32_ok_s2 <= (sum[63:32] == 32'd0);
			s32_ok_s2 <= fits_s32(sum);
		end
		if (rdy3 && v_s2) begin
			st_s3     <= r_st;
			placed_s3 <= done_s2 ? placed_s2 : 32'd0;
			addr_s3   <= r_addr;
			data_s3   <= r_data;
			bytes_s3  <= r_bytes;
		end
	end

	assign out_valid     = v_s3;
	assign status        = st_s3;
	assign placed_offset = placed_s3;
	assign patch_addr    = addr_s3;
	assign patch_data    = data_s3;
	assign patch_bytes   = bytes_s3;

	`ESLR_ASSERT_IMPL(a_err_clean, clk, arst_n, v_s3 && st_s3 != ST_OK,
		addr_s3 == 64'd0 && data_s3 == 64'd0 && bytes_s3 == 4'd0, "error beat carries a patch")
	`ESLR_ASSERT_IMPL(a_bytes_legal, clk, arst_n, v_s3,
		bytes_s3 == 4'd0 || bytes_s3 == 4'd4 || bytes_s3 == 4'd8, "illegal patch width")
	`ESLR_ASSERT_IMPL(a_narrow_data, clk, arst_n, v_s3 && bytes_s3 == 4'd4,
		data_s3[63:32] == 32'd0, "4-byte patch with upper data bits set")
	`ESLR_ASSERT_IMPL(a_pop_legal, clk, arst_n, pop, !q_empty, "back popped an empty queue")

endmodule

// File: src/elf_section_layout_and_relocation_core.sv
// Top level of the ELF x86-64 section layout and RELA relocation core.
// Depends on eslr_pkg, eslr_front, eslr_queue, eslr_back and eslr_ram.
//
//   channel   direction   handshake              payload
//   in        sink        in_valid / in_stall    cmd .. addend (one item per beat)
//   out       source      out_valid / out_stall  status .. patch_bytes (one result per item)
//   config    APB slave   psel/penable/pwrite    dest_base @0, dest_len @8, image_limit @16
//
// Throughput is one item per cycle while in_stall is low; the limit is the layout cursor,
// which is aligned, checked and advanced in the same cycle a section beat is accepted.
// An input beat passes through the front stage, the queue, then three back stages
// (addresses, S+A, final value and range check) on its way to the result beat.
// Reset clears the cursor, the section count and all valids and resets the config; the
// section tables need no clearing since only entries below the count are used.
// A stall on the output backs up the back stages, then the queue, and only then
// raises in_stall; the front and back keep working independently until then.
`include "elf_section_layout_and_relocation_core_macros.svh"
module elf_section_layout_and_relocation_core #(
	parameter int MAX_SECTIONS = eslr_pkg::MAX_SECTIONS_DEF,
	parameter int QUEUE_DEPTH  = eslr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,

	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic        sec_alloc,
	input  logic [1:0]  sec_kind,
	input  logic [63:0] sec_align,
	input  logic [63:0] sec_size,
	input  logic [31:0] rel_type,
	input  logic [63:0] rel_offset,
	input  logic [5:0]  rel_target,
	input  logic [15:0] sym_shndx,
	input  logic [63:0] sym_value,
	input  logic [63:0] resolved_addr,
	input  logic [63:0] addend,

	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] placed_offset,
	output logic [63:0] patch_addr,
	output logic [63:0] patch_data,
	output logic [3:0]  patch_bytes
);
	import eslr_pkg::*;

	cfg_t        cfg_q;
	logic        cfg_wr;
	logic        push;
	rec_t        push_rec;
	logic        q_full;
	logic        q_empty;
	logic        pop;
	rec_t        q_dout;

	// Register write completes on the access phase; the port never waits.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_base   <= 64'd0;
			cfg_q.dest_len    <= 32'd0;
			cfg_q.image_limit <= IMAGE_LIMIT_RST;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				REG_DEST_BASE:   cfg_q.dest_base   <= pwdata;
				REG_DEST_LEN:    cfg_q.dest_len    <= pwdata[31:0];
				REG_IMAGE_LIMIT: cfg_q.image_limit <= pwdata[31:0];
				default: begin
					// drop writes past the register list
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_DEST_BASE:   prdata = cfg_q.dest_base;
			REG_DEST_LEN:    prdata = {32'd0, cfg_q.dest_len};
			REG_IMAGE_LIMIT: prdata = {32'd0, cfg_q.image_limit};
			default:         prdata = 64'd0;
		endcase
	end

	// Front: accept, lay out sections, classify relocations
	eslr_front #(.MAX_SECTIONS(MAX_SECTIONS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.sec_alloc     (sec_alloc),
		.sec_kind      (sec_kind),
		.sec_align     (sec_align),
		.sec_size      (sec_size),
		.rel_type      (rel_type),
		.rel_offset    (rel_offset),
		.rel_target    (rel_target),
		.sym_shndx     (sym_shndx),
		.sym_value     (sym_value),
		.resolved_addr (resolved_addr),
		.addend        (addend),
		.push          (push),
		.push_rec      (push_rec),
		.q_full        (q_full)
	);

	// Decouple the two halves
	eslr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_rec),
		.full   (q_full),
		.pop    (pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	// Back: compute relocation values and hold the result beat
	eslr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_dout        (q_dout),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.placed_offset (placed_offset),
		.patch_addr    (patch_addr),
		.patch_data    (patch_data),
		.patch_bytes   (patch_bytes)
	);

	`ESLR_ASSERT_IMPL(a_stall_means_full, clk, arst_n, in_stall, q_full,
		"input stalled while the queue had room")
	`ESLR_ASSERT_NEXT(a_cfg_written, clk, arst_n, cfg_wr && paddr[4:3] == REG_DEST_BASE,
		cfg_q.dest_base == $past(pwdata), "dest_base write did not land")
	`ESLR_ASSERT_ALWAYS(a_limit_nonzero_after_reset, clk, arst_n,
		!$rose(arst_n) || cfg_q.image_limit == IMAGE_LIMIT_RST, "image_limit reset value wrong")

endmodule
